### rtl/tfq_pkg.sv
// Shared types, widths, level codes and configuration indexes for the
// three-level feedback queue scheduler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfq_pkg;

    // Ring geometry. Pointers and counts are derived from the ring depth.
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int TASK_W     = 4;
    localparam int LEVEL_W    = 2;
    localparam int SLICE_W    = 8;
    localparam int NUM_LEVELS = 3;
    localparam int CFG_IDX_W  = 2;

    typedef logic [LEVEL_W-1:0] t_level;

    localparam t_level LVL_TOP  = 2'd0;
    localparam t_level LVL_MID  = 2'd1;
    localparam t_level LVL_BOT  = 2'd2;
    localparam t_level LVL_IDLE = 2'd3;

    typedef enum logic {
        ACT_ADMIT   = 1'b0,
        ACT_RESCHED = 1'b1
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_SLICE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_SLICE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOT_SLICE = 2'd2;

    localparam logic [SLICE_W-1:0] TOP_SLICE_RST = 8'd1;
    localparam logic [SLICE_W-1:0] MID_SLICE_RST = 8'd2;
    localparam logic [SLICE_W-1:0] BOT_SLICE_RST = 8'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### rtl/three_level_feedback_queue_scheduler.sv
// An item passes the update, fetch and output states before its result
// is loaded, and no new item is taken meanwhile: the ring RAMs' registered
// read port must return the heads before and after each update.
// A stalled output holds the controller in its output state until taken.
// Reset (synchronous, active low) empties all queues, selects the idle task
// and restores the slices to 1, 2 and 4 ticks; the ring RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module three_level_feedback_queue_scheduler import tfq_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input item channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_action,
    input  wire logic [TASK_W-1:0]    i_task_id,
    input  wire logic                 i_still_ready,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SLICE_W-1:0]   i_cfg_data,
    // Result item channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [TASK_W-1:0]    o_running_task,
    output logic      [LEVEL_W-1:0]   o_running_level,
    output logic      [SLICE_W-1:0]   o_granted_slice,
    output logic                      o_idle_selected,
    output logic                      o_admit_dropped
);

    // The controller steps each item through four phases. In the wait phase
    // it accepts an item and latches it. In the update phase the datapath
    // uses the head of the running level, already read from its ring, to
    // remove that task, demote it if it is still ready and pick the highest
    // non-empty level, or appends an admitted task to the top ring.
    // The fetch phase lets the rings read their new heads, and the output
    // phase loads the result register once it is free. The output register
    // parts the two channels, so one waiting result does not stall the input;
    // the next item is then processed and held in the output phase until the
    // waiting result has been taken.
    t_cmd    cmd;
    t_status status;

    tfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tfq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_action        (i_action),
        .i_task_id       (i_task_id),
        .i_still_ready   (i_still_ready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_running_task  (o_running_task),
        .o_running_level (o_running_level),
        .o_granted_slice (o_granted_slice),
        .o_idle_selected (o_idle_selected),
        .o_admit_dropped (o_admit_dropped)
    );

    // An accepted item keeps the input closed while it is being processed.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input reopened directly after an accepted item");

    // While a result is valid, the idle flag and the idle level code agree.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_idle_selected == (o_running_level == LVL_IDLE)))
        else $error("idle flag disagrees with the reported level");

    // The idle task carries no task number and no slice.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_idle_selected)
            |-> (o_granted_slice == '0) && (o_running_task == '0))
        else $error("idle result carries a task or a slice");

endmodule

`default_nettype wire

### rtl/tfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tfq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old contents when the same address is written.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/tfq_ctrl.sv
// Sequencing state machine of the scheduler: accept, update, fetch, output.
// Depends on tfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfq_ctrl import tfq_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_WAIT   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_FETCH  = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.update    = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            S_WAIT: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold here until the output register can take the result.
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_WAIT;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/tfq_dp.sv
// Datapath of the scheduler: ring RAMs, head/tail/count registers, level
// selection, slice registers and the output register. Depends on tfq_pkg
// and tfq_ram.
`timescale 1ns / 1ps
`default_nettype none

module tfq_dp import tfq_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic                 i_action,
    input  wire logic [TASK_W-1:0]    i_task_id,
    input  wire logic                 i_still_ready,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SLICE_W-1:0]   i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [TASK_W-1:0]    o_running_task,
    output logic      [LEVEL_W-1:0]   o_running_level,
    output logic      [SLICE_W-1:0]   o_granted_slice,
    output logic                      o_idle_selected,
    output logic                      o_admit_dropped
);

    // Latched input item.
    t_action           r_action;
    logic [TASK_W-1:0] r_task;
    logic              r_still_ready;

    // Ring bookkeeping and scheduler state.
    logic [PTR_W-1:0]   r_head  [NUM_LEVELS];
    logic [PTR_W-1:0]   r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]   r_count [NUM_LEVELS];
    logic [PTR_W-1:0]   n_head  [NUM_LEVELS];
    logic [PTR_W-1:0]   n_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]   n_count [NUM_LEVELS];
    t_level             r_cur_level;
    t_level             n_cur_level;
    logic               r_dropped;
    logic               n_dropped;
    logic [SLICE_W-1:0] r_slice [NUM_LEVELS];

    // RAM ports.
    logic              ram_we    [NUM_LEVELS];
    logic [TASK_W-1:0] ram_rdata [NUM_LEVELS];
    logic [TASK_W-1:0] ram_wdata;

    // Working signals.
    logic [TASK_W-1:0]  was_task;
    logic [CNT_W-1:0]   cur_count;
    logic               popping;
    t_level             dest_level;
    logic               pop_k;
    logic               push_req_k;
    logic               push_k;
    logic [CNT_W-1:0]   mid_count;
    logic [TASK_W-1:0]  sel_task;
    logic [SLICE_W-1:0] sel_slice;
    logic               sel_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_ring
        tfq_ram #(
            .WIDTH (TASK_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ring (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (r_tail[g]),
            .i_wdata (ram_wdata),
            .i_raddr (r_head[g]),
            .o_rdata (ram_rdata[g])
        );
    end

    // Head task, count and slice of the current level.
    always_comb begin
        case (r_cur_level)
            LVL_TOP: begin
                was_task  = ram_rdata[0];
                cur_count = r_count[0];
                sel_slice = r_slice[0];
            end
            LVL_MID: begin
                was_task  = ram_rdata[1];
                cur_count = r_count[1];
                sel_slice = r_slice[1];
            end
            LVL_BOT: begin
                was_task  = ram_rdata[2];
                cur_count = r_count[2];
                sel_slice = r_slice[2];
            end
            default: begin
                was_task  = '0;
                cur_count = '0;
                sel_slice = '0;
            end
        endcase
        sel_valid = (r_cur_level != LVL_IDLE) && (cur_count != '0);
        sel_task  = was_task;
    end

    // Next state of the rings for the latched item.
    always_comb begin
        popping    = (r_action == ACT_RESCHED) && (r_cur_level != LVL_IDLE)
                     && (cur_count != '0);
        dest_level = (r_cur_level == LVL_BOT) ? LVL_BOT : r_cur_level + t_level'(1);
        ram_wdata  = (r_action == ACT_ADMIT) ? r_task : was_task;
        n_dropped  = (r_action == ACT_ADMIT)
                     && !(r_count[0] < CNT_W'(QUEUE_DEPTH));
        pop_k      = 1'b0;
        push_req_k = 1'b0;
        push_k     = 1'b0;
        mid_count  = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            pop_k = popping && (r_cur_level == LEVEL_W'(k));
            if (r_action == ACT_ADMIT) begin
                push_req_k = (k == 0);
            end else begin
                push_req_k = popping && r_still_ready && (dest_level == LEVEL_W'(k));
            end
            mid_count  = r_count[k] - CNT_W'(pop_k);
            push_k     = push_req_k && (mid_count < CNT_W'(QUEUE_DEPTH));
            n_count[k] = mid_count + CNT_W'(push_k);
            n_head[k]  = pop_k ? next_ptr(r_head[k]) : r_head[k];
            n_tail[k]  = push_k ? next_ptr(r_tail[k]) : r_tail[k];
            ram_we[k]  = i_cmd.update && push_k;
        end
        if (r_action == ACT_ADMIT) begin
            n_cur_level = r_cur_level;
        end else if (n_count[0] != '0) begin
            n_cur_level = LVL_TOP;
        end else if (n_count[1] != '0) begin
            n_cur_level = LVL_MID;
        end else if (n_count[2] != '0) begin
            n_cur_level = LVL_BOT;
        end else begin
            n_cur_level = LVL_IDLE;
        end
    end

    assign o_status.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
            r_cur_level <= LVL_IDLE;
            r_slice[0]  <= TOP_SLICE_RST;
            r_slice[1]  <= MID_SLICE_RST;
            r_slice[2]  <= BOT_SLICE_RST;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                for (int k = 0; k < NUM_LEVELS; k++) begin
                    r_head[k]  <= n_head[k];
                    r_tail[k]  <= n_tail[k];
                    r_count[k] <= n_count[k];
                end
                r_cur_level <= n_cur_level;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TOP_SLICE: r_slice[0] <= i_cfg_data;
                    CFG_MID_SLICE: r_slice[1] <= i_cfg_data;
                    CFG_BOT_SLICE: r_slice[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action      <= t_action'(i_action);
            r_task        <= i_task_id;
            r_still_ready <= i_still_ready;
        end
        if (i_cmd.update) begin
            r_dropped <= n_dropped;
        end
        if (i_cmd.load_out) begin
            o_admit_dropped <= r_dropped;
            if (sel_valid) begin
                o_running_task  <= sel_task;
                o_running_level <= r_cur_level;
                o_granted_slice <= sel_slice;
                o_idle_selected <= 1'b0;
            end else begin
                o_running_task  <= '0;
                o_running_level <= LVL_IDLE;
                o_granted_slice <= '0;
                o_idle_selected <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### tb/three_level_feedback_queue_scheduler_test.sv
// Self-checking testbench for the three-level feedback queue scheduler.
// It holds its own model of the rings and the level pick. It needs only tfq_pkg
// and the scheduler RTL.
`timescale 1ns / 1ps

module three_level_feedback_queue_scheduler_test;
    import tfq_pkg::*;

    // Run limits. The block works on one item at a time. Random gaps, receiver
    // stalls and the long hold-off slow it further. The limit leaves a wide
    // margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 180;
    localparam int MAX_PRINTED  = 50;

    // One scheduler event as the sender offers it.
    typedef struct packed {
        t_action           act;
        logic [TASK_W-1:0] task_id;
        logic              still_ready;
    } sched_event_t;

    // One selection as the block should report it.
    typedef struct packed {
        logic [TASK_W-1:0]  run_task;
        logic [LEVEL_W-1:0] run_level;
        logic [SLICE_W-1:0] slice;
        logic               idle;
        logic               dropped;
    } selection_t;

    // Clock, reset and every input of the block start at known values.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 ev_action   = 1'b0;
    logic [TASK_W-1:0]    ev_task_id  = '0;
    logic                 ev_ready    = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [SLICE_W-1:0]   cfg_data    = '0;
    logic                 out_ready   = 1'b0;

    wire                  o_in_ready;
    wire                  o_out_valid;
    wire [TASK_W-1:0]     o_running_task;
    wire [LEVEL_W-1:0]    o_running_level;
    wire [SLICE_W-1:0]    o_granted_slice;
    wire                  o_idle_selected;
    wire                  o_admit_dropped;

    three_level_feedback_queue_scheduler uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (ev_action),
        .i_task_id       (ev_task_id),
        .i_still_ready   (ev_ready),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_running_task  (o_running_task),
        .o_running_level (o_running_level),
        .o_granted_slice (o_granted_slice),
        .o_idle_selected (o_idle_selected),
        .o_admit_dropped (o_admit_dropped)
    );

    always #2 i_clk = ~i_clk;

    // Events waiting to be offered, and selections still to come back.
    sched_event_t pending_events[$];
    selection_t   expected_selections[$];

    // Idling controls, set by the sequence between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Long receiver hold-off: the sequence toggles hold_arm, and the counter
    // process below loads and counts down the stretch itself.
    bit          hold_arm      = 1'b0;
    bit          hold_arm_seen = 1'b0;
    int unsigned hold_left     = 0;

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;

    // Statistics for the closing summary.
    int unsigned admits_seen      = 0;
    int unsigned reschedules_seen = 0;
    int unsigned drops_predicted  = 0;
    int unsigned demotions_lost   = 0;
    int unsigned idle_predicted   = 0;
    int unsigned settings_used    = 1;

    // ------------------------------------------------------------------
    // Scheduler model: three rings of task ids, with their read and write
    // positions, their fill levels, the level now running and the slices.
    // ------------------------------------------------------------------
    logic [TASK_W-1:0]  ring_mem   [NUM_LEVELS][QUEUE_DEPTH];
    int unsigned        rd_pos     [NUM_LEVELS];
    int unsigned        wr_pos     [NUM_LEVELS];
    int unsigned        fill       [NUM_LEVELS];
    t_level             run_lvl;
    logic [SLICE_W-1:0] slice_reg  [NUM_LEVELS];

    // Appends a task to the tail of one ring. It returns 0 when the ring is
    // full, in which case the task is not stored.
    function automatic bit enqueue_task(input t_level lvl, input logic [TASK_W-1:0] tid);
        if (fill[lvl] >= QUEUE_DEPTH) return 1'b0;
        ring_mem[lvl][wr_pos[lvl]] = tid;
        wr_pos[lvl] = (wr_pos[lvl] + 1) % QUEUE_DEPTH;
        fill[lvl]++;
        return 1'b1;
    endfunction

    // Applies one accepted event to the model and queues the selection that
    // the block must report for it.
    function automatic void predict_selection(input sched_event_t ev);
        selection_t        sel;
        logic [TASK_W-1:0] leaving;
        t_level            lower;
        sel.dropped = 1'b0;
        if (ev.act == ACT_ADMIT) begin
            admits_seen++;
            // An admit never reschedules. An idle block stays idle.
            if (!enqueue_task(LVL_TOP, ev.task_id)) begin
                sel.dropped = 1'b1;
                drops_predicted++;
            end
        end else begin
            reschedules_seen++;
            // The running task leaves the head of its ring. If it is still
            // ready it moves one level down; the bottom level feeds itself.
            if (run_lvl != LVL_IDLE && fill[run_lvl] > 0) begin
                leaving = ring_mem[run_lvl][rd_pos[run_lvl]];
                rd_pos[run_lvl] = (rd_pos[run_lvl] + 1) % QUEUE_DEPTH;
                fill[run_lvl]--;
                lower = (run_lvl == LVL_BOT) ? LVL_BOT : t_level'(run_lvl + 1);
                if (ev.still_ready && !enqueue_task(lower, leaving))
                    demotions_lost++;
            end
            if (fill[LVL_TOP] > 0)      run_lvl = LVL_TOP;
            else if (fill[LVL_MID] > 0) run_lvl = LVL_MID;
            else if (fill[LVL_BOT] > 0) run_lvl = LVL_BOT;
            else                        run_lvl = LVL_IDLE;
        end
        if (run_lvl != LVL_IDLE && fill[run_lvl] > 0) begin
            sel.run_task  = ring_mem[run_lvl][rd_pos[run_lvl]];
            sel.run_level = run_lvl;
            sel.slice     = slice_reg[run_lvl];
            sel.idle      = 1'b0;
        end else begin
            sel.run_task  = '0;
            sel.run_level = LVL_IDLE;
            sel.slice     = '0;
            sel.idle      = 1'b1;
            idle_predicted++;
        end
        expected_selections.push_back(sel);
    endfunction

    // Every failed check goes through here. Only the first MAX_PRINTED are printed,
    // so that a badly broken block cannot flood the log.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // Driver. It offers the oldest pending event. While valid is high and the
    // item has not been taken, it leaves the payload alone. Each signal gets
    // at most one assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_events
        bit taken;
        taken = in_valid && o_in_ready;
        if (taken) begin
            predict_selection(pending_events.pop_front());
        end
        if (in_valid && !taken) begin
            // Hold the current item until it is taken.
        end else if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            in_valid   <= 1'b1;
            ev_action  <= pending_events[0].act;
            ev_task_id <= pending_events[0].task_id;
            ev_ready   <= pending_events[0].still_ready;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each accepted result is checked against the oldest expected
    // selection. After that, ready is chosen for the next edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_selections
        selection_t want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_selections.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected (task %0d level %0d)",
                                          o_running_task, o_running_level));
            end else begin
                want = expected_selections.pop_front();
                if (o_running_task !== want.run_task)
                    report_mismatch($sformatf("running_task %0d, expected %0d",
                                              o_running_task, want.run_task));
                if (o_running_level !== want.run_level)
                    report_mismatch($sformatf("running_level %0d, expected %0d",
                                              o_running_level, want.run_level));
                if (o_granted_slice !== want.slice)
                    report_mismatch($sformatf("granted_slice %0d, expected %0d",
                                              o_granted_slice, want.slice));
                if (o_idle_selected !== want.idle)
                    report_mismatch($sformatf("idle_selected %0b, expected %0b",
                                              o_idle_selected, want.idle));
                if (o_admit_dropped !== want.dropped)
                    report_mismatch($sformatf("admit_dropped %0b, expected %0b",
                                              o_admit_dropped, want.dropped));
            end
        end
        if (hold_left != 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold-off counter. It runs in its own process so that the stretch is
    // counted in clock cycles whatever the sequence is doing.
    always @(posedge i_clk) begin
        if (hold_arm != hold_arm_seen) begin
            hold_arm_seen <= hold_arm;
            hold_left     <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog. A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d events and %0d results outstanding",
                     cycle_count, pending_events.size(), expected_selections.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers.
    // ------------------------------------------------------------------
    task automatic add_event(input t_action act, input logic [TASK_W-1:0] tid,
                             input logic ready);
        sched_event_t ev;
        ev.act         = act;
        ev.task_id     = tid;
        ev.still_ready = ready;
        pending_events.push_back(ev);
    endtask

    // Waits until every event has been taken and every selection checked.
    // It then allows the block's latency to run out.
    task automatic wait_until_drained();
        while (pending_events.size() != 0 || in_valid || expected_selections.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one slice register. The block takes the write at the edge that ends the task, and the
    // model takes the new value at that point.
    task automatic write_slice(input logic [CFG_IDX_W-1:0] idx, input logic [SLICE_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        slice_reg[idx] = val;
    endtask

    task automatic set_slices(input logic [SLICE_W-1:0] top_val,
                              input logic [SLICE_W-1:0] mid_val,
                              input logic [SLICE_W-1:0] bot_val);
        write_slice(CFG_TOP_SLICE, top_val);
        write_slice(CFG_MID_SLICE, mid_val);
        write_slice(CFG_BOT_SLICE, bot_val);
        settings_used++;
    endtask

    // Random traffic. Most of it comes as bursts of admits followed by runs
    // of reschedules. These fill the rings, drain them through the levels and
    // push demotions into full rings. The rest is unordered noise.
    task automatic random_traffic(input int unsigned count);
        int unsigned made;
        int unsigned n_admit;
        int unsigned n_resched;
        int unsigned n_noise;
        made = 0;
        while (made < count) begin
            if ($urandom_range(9) < 7) begin
                n_admit   = $urandom_range(20, 1);
                n_resched = $urandom_range(40, 1);
                // The last burst is trimmed so that the phase ends on its count.
                if (n_admit > count - made)
                    n_admit = count - made;
                if (n_resched > count - made - n_admit)
                    n_resched = count - made - n_admit;
                repeat (n_admit)
                    add_event(ACT_ADMIT, TASK_W'($urandom_range(15)),
                              1'($urandom_range(1)));
                repeat (n_resched)
                    add_event(ACT_RESCHED, TASK_W'($urandom_range(15)),
                              $urandom_range(99) < 80);
                made += n_admit + n_resched;
            end else begin
                n_noise = $urandom_range(8, 1);
                if (n_noise > count - made)
                    n_noise = count - made;
                repeat (n_noise)
                    add_event(t_action'($urandom_range(1)), TASK_W'($urandom_range(15)),
                              1'($urandom_range(1)));
                made += n_noise;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
            rd_pos[lvl] = 0;
            wr_pos[lvl] = 0;
            fill[lvl]   = 0;
        end
        run_lvl = LVL_IDLE;
        slice_reg[LVL_TOP] = TOP_SLICE_RST;
        slice_reg[LVL_MID] = MID_SLICE_RST;
        slice_reg[LVL_BOT] = BOT_SLICE_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part, run with the reset slices. First a reschedule while
        // idle, then admits to an idle block, which must stay idle.
        add_event(ACT_RESCHED, 4'd0,  1'b1);
        add_event(ACT_ADMIT,   4'd0,  1'b0);
        add_event(ACT_ADMIT,   4'd15, 1'b1);
        // Leave idle, then walk a task down through every level.
        add_event(ACT_RESCHED, 4'd5,  1'b1);
        add_event(ACT_RESCHED, 4'd10, 1'b1);
        add_event(ACT_RESCHED, 4'd0,  1'b0);
        add_event(ACT_RESCHED, 4'd15, 1'b1);
        // The bottom level feeds itself, then the last task finishes.
        add_event(ACT_RESCHED, 4'd0,  1'b1);
        add_event(ACT_RESCHED, 4'd0,  1'b0);
        // Overfill the top ring: the last admit must be dropped.
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            add_event(ACT_ADMIT, 4'(15 - i), 1'(i));
        wait_until_drained();

        // Phase with no idling. A long receiver hold-off at its start backs
        // the block up until it refuses input.
        set_slices(8'd255, 8'd1, 8'd255);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_arm = ~hold_arm;
        random_traffic(PHASE_ITEMS);
        wait_until_drained();

        // Phase with a mostly idle sender.
        set_slices(8'd1, 8'd255, 8'd1);
        send_idle_pct = 66;
        random_traffic(PHASE_ITEMS);
        wait_until_drained();

        // Phase with a mostly stalled receiver.
        set_slices(SLICE_W'($urandom_range(255, 1)), SLICE_W'($urandom_range(255, 1)),
                   SLICE_W'($urandom_range(255, 1)));
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        random_traffic(PHASE_ITEMS);
        wait_until_drained();

        // Phase where both sides pause now and then.
        set_slices(8'd128, SLICE_W'($urandom_range(255, 1)), 8'd255);
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        random_traffic(PHASE_ITEMS);
        wait_until_drained();

        if (expected_selections.size() != 0)
            report_mismatch($sformatf("%0d selections never arrived",
                                      expected_selections.size()));

        $display("Ran %0d admits and %0d reschedules over %0d slice settings.",
                 admits_seen, reschedules_seen, settings_used);
        $display("Saw %0d dropped admits, %0d demotions into full rings, %0d idle picks.",
                 drops_predicted, demotions_lost, idle_predicted);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
